/* rtl/alsn_pkg.sv */
// Shared types, constants, fixed-point helpers and the normalization table.
package alsn_pkg;

    localparam int DEG_LIMIT = 9;
    localparam int NDIM      = DEG_LIMIT + 1;
    localparam int NORM_N    = NDIM * NDIM;
    localparam int NORM_IW   = $clog2(NORM_N);

    localparam logic signed [63:0] SMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

    // configuration register indexes
    localparam logic [1:0] REG_TOP_ORDER  = 2'd0;
    localparam logic [1:0] REG_SIGN_FLIP  = 2'd1;
    localparam logic [1:0] REG_ZONAL_ONLY = 2'd2;

    localparam logic [127:0] ONE_E18     = 128'd1000000000000000000;
    localparam logic [127:0] SQRT4PI_E18 = 128'd3544907701811032055;
    localparam logic [127:0] INV_SQRT4PI = ((128'd1 << 62) * ONE_E18) / SQRT4PI_E18;

    typedef enum logic {
        SHIFT_Q32,
        SHIFT_Q66
    } mul_shift_t;

    typedef struct packed {
        logic              start;
        mul_shift_t        shift;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic [3:0]         divisor;
    } div_req_t;

    typedef logic [NORM_N-1:0][63:0] norm_tab_t;

    // floor(v / k), bit at a time
    function automatic logic [127:0] div_small(input logic [127:0] v, input logic [4:0] k);
        logic [127:0] q;
        logic [5:0]   r;
        q = '0;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            r = {r[4:0], v[i]};
            if (r >= {1'b0, k}) begin
                r    = r - {1'b0, k};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt128(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (({64'd0, c} * {64'd0, c}) <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    // N(n,m) in Q62, worked out at elaboration
    function automatic norm_tab_t build_norm();
        norm_tab_t    tab;
        logic [127:0] w;
        logic [127:0] p;
        logic [63:0]  r;
        tab = '0;
        for (int n = 0; n <= DEG_LIMIT; n++) begin
            for (int m = 0; m <= n; m++) begin
                w = 128'(2 * n + 1) << 120;
                for (int k = n - m + 1; k <= n + m; k++) begin
                    w = div_small(w, 5'(k));
                end
                r = isqrt128(w);
                p = (INV_SQRT4PI * {64'd0, r} + (128'd1 << 59)) >> 60;
                tab[n * NDIM + m] = (p > 128'(SMAX)) ? SMAX : p[63:0];
            end
        end
        return tab;
    endfunction

    localparam norm_tab_t NORM_TAB = build_norm();

    // t * k for a small positive k, saturated to +-SMAX
    function automatic logic signed [63:0] mul_small_sat(input logic signed [63:0] t,
                                                         input logic [4:0] k);
        logic [63:0] mag;
        logic [68:0] prod;
        logic [63:0] res;
        mag  = t[63] ? (64'd0 - t) : t;
        prod = {5'd0, mag} * {64'd0, k};
        res  = (prod > 69'(SMAX)) ? SMAX : prod[63:0];
        return t[63] ? -$signed(res) : $signed(res);
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b);
        if (d > 65'(SMAX)) begin
            return SMAX;
        end
        if (d < -65'(SMAX)) begin
            return -SMAX;
        end
        return d[63:0];
    endfunction

endpackage

/* rtl/alsn_mul.sv */
// Shared 64x64 fixed-point multiplier: four 32x32 partial products, round, saturate.
module alsn_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  alsn_pkg::mul_req_t req,
    output logic               done,
    output logic signed [63:0] res
);

    localparam logic [2:0] LAST_STEP = 3'd5;
    localparam logic [2:0] PP_COUNT  = 3'd4;

    logic                 busy_reg;
    logic                 done_reg;
    logic [2:0]           step_reg;
    logic                 neg_reg;
    logic [63:0]          ua_reg;
    logic [63:0]          ub_reg;
    alsn_pkg::mul_shift_t shift_reg;
    logic [63:0]          prod_reg;
    logic [1:0]           psh_reg;
    logic [127:0]         acc_reg;
    logic signed [63:0]   res_reg;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] round_sum;
    logic [127:0] shifted;
    logic [63:0]  mag;

    assign a_part = step_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_part = step_reg[0] ? ub_reg[63:32] : ub_reg[31:0];

    always_comb begin
        if (shift_reg == alsn_pkg::SHIFT_Q66) begin
            round_sum = acc_reg + (128'd1 << 65);
            shifted   = round_sum >> 66;
        end else begin
            round_sum = acc_reg + (128'd1 << 31);
            shifted   = round_sum >> 32;
        end
        mag = (|shifted[127:63]) ? alsn_pkg::SMAX : shifted[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg   <= req.a[63] ^ req.b[63];
            ua_reg    <= req.a[63] ? (64'd0 - req.a) : req.a;
            ub_reg    <= req.b[63] ? (64'd0 - req.b) : req.b;
            shift_reg <= req.shift;
            acc_reg   <= '0;
        end else if (busy_reg) begin
            if (step_reg < PP_COUNT) begin
                prod_reg <= 64'(a_part) * 64'(b_part);
                psh_reg  <= 2'(step_reg[1]) + 2'(step_reg[0]);
            end
            if (step_reg != 3'd0 && step_reg <= PP_COUNT) begin
                acc_reg <= acc_reg + (128'(prod_reg) << {psh_reg, 5'd0});
            end
            if (step_reg == LAST_STEP) begin
                res_reg <= neg_reg ? (64'd0 - mag) : mag;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* rtl/alsn_sqrt.sv */
// Digit-by-digit floor square root of (1 - x^2) taken to Q32.
module alsn_sqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] radicand,
    output logic               done,
    output logic [32:0]        root
);

    localparam logic [5:0] LAST_CNT = 6'd32;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [65:0] rad_reg;
    logic [36:0] rem_reg;
    logic [32:0] root_reg;

    logic [36:0] rem_t;
    logic [36:0] trial;
    logic        fits;

    assign rem_t = {rem_reg[34:0], rad_reg[65:64]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = (rem_t >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST_CNT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // non-positive radicand gives a zero root
            rad_reg  <= (radicand <= 32'sd0) ? '0 : {radicand[29:0], 36'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? (rem_t - trial) : rem_t;
            root_reg <= {root_reg[31:0], fits};
            rad_reg  <= rad_reg << 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/alsn_div.sv */
// Signed divide by a small positive integer, eight quotient bits per cycle, toward zero.
module alsn_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  alsn_pkg::div_req_t req,
    output logic               done,
    output logic signed [63:0] quo
);

    localparam int         DIV_BITS = 8;
    localparam logic [2:0] LAST_STEP = 3'd7;

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  step_reg;
    logic        neg_reg;
    logic [63:0] num_reg;
    logic [3:0]  den_reg;
    logic [3:0]  rem_reg;
    logic [63:0] quo_reg;

    logic [3:0]          part_rem;
    logic [4:0]          trial;
    logic [DIV_BITS-1:0] digit;

    always_comb begin
        part_rem = rem_reg;
        digit    = '0;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {part_rem, num_reg[63 - i]};
            if (trial >= {1'b0, den_reg}) begin
                trial                 = trial - {1'b0, den_reg};
                digit[DIV_BITS-1-i]   = 1'b1;
            end
            part_rem = trial[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg <= req.dividend[63];
            num_reg <= req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << DIV_BITS;
            rem_reg <= part_rem;
            quo_reg <= {quo_reg[63-DIV_BITS:0], digit};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (64'd0 - quo_reg) : quo_reg;

endmodule

/* rtl/assoc_legendre_sph_norm.sv */
// Top level: sequencer, recurrence value memory, output register and config registers.
//
// One argument x (Q2.14) yields every normalized P_n^m(x) for n up to top_order, in order
// n then m (only m = 0 in zonal mode), with last set on the final word. A new argument is
// taken only once all its values are handed to the output register; the last word may
// still wait there. At top degree 9 an argument first needs a square root; then each of
// the 54 recurrence terms costs one pass of the shared 64x64 multiplier (four 32x32
// partial products), with a divider pass for the three-term terms, and each of the 55
// results costs a memory read plus a further multiplier pass. The raw values are kept
// in an on-chip memory of (MAX_DEGREE+1)^2 words between the two phases.
module assoc_legendre_sph_norm #(
    parameter int MAX_DEGREE = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_arg_x,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_degree_n,
    output logic [3:0]         m_mode_m,
    output logic signed [31:0] m_value,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data
);

    localparam int MEM_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_SQRT      = 10'b00_0000_0010,
        ST_DIAG      = 10'b00_0000_0100,
        ST_LOW       = 10'b00_0000_1000,
        ST_REC       = 10'b00_0001_0000,
        ST_DIV       = 10'b00_0010_0000,
        ST_EMIT_RD   = 10'b00_0100_0000,
        ST_EMIT_GO   = 10'b00_1000_0000,
        ST_EMIT_WAIT = 10'b01_0000_0000,
        ST_EMIT_PUSH = 10'b10_0000_0000
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [3:0] nn, input logic [3:0] mm);
        return ADDR_W'(8'(nn) * 8'(MAX_DEGREE + 1) + 8'(mm));
    endfunction

    state_t state_reg, state_next;

    logic [3:0] top_order_reg;
    logic       sign_flip_reg;
    logic       zonal_only_reg;

    logic [15:0]        xs_reg, xs_next;
    logic [3:0]         top_reg, top_next;
    logic               sign_reg, sign_next;
    logic               zonal_reg, zonal_next;
    logic [3:0]         n_reg, n_next;
    logic [3:0]         m_reg, m_next;
    logic [32:0]        s_reg, s_next;
    logic signed [63:0] diag_reg, diag_next;
    logic signed [63:0] prev1_reg, prev1_next;
    logic signed [63:0] prev2_reg, prev2_next;

    logic               m_valid_reg;
    logic [3:0]         m_degree_n_reg;
    logic [3:0]         m_mode_m_reg;
    logic signed [31:0] m_value_reg;
    logic               m_last_reg;

    logic signed [63:0] pmem [MEM_DEPTH];
    logic signed [63:0] rd_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic signed [63:0] mem_wdata;

    alsn_pkg::mul_req_t mul_req;
    logic               mul_done;
    logic signed [63:0] mul_res;
    alsn_pkg::div_req_t div_req;
    logic               div_done;
    logic signed [63:0] div_quo;
    logic               sq_start;
    logic               sq_done;
    logic [32:0]        sq_root;
    logic signed [31:0] sq_radicand;

    logic [3:0]                   top_eff;
    logic signed [63:0]           xq;
    logic signed [63:0]           s_wide;
    logic signed [63:0]           diag_mag, diag_val, low_val;
    logic signed [63:0]           rec_a, rec_b, rec_d;
    logic [alsn_pkg::NORM_IW-1:0] norm_idx;
    logic signed [31:0]           value_clamped;
    logic                         is_last;
    logic                         out_load;

    assign top_eff = (top_order_reg > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : top_order_reg;
    assign xq      = {{30{xs_reg[15]}}, xs_reg, 18'd0};
    assign s_wide  = {31'd0, s_reg};
    assign sq_radicand = 32'sd268435456 - ($signed(s_arg_x) * $signed(s_arg_x));

    assign diag_mag = alsn_pkg::mul_small_sat(mul_res, {m_reg, 1'b0} - 5'd1);
    assign diag_val = sign_reg ? -diag_mag : diag_mag;
    assign low_val  = alsn_pkg::mul_small_sat(mul_res, {m_reg, 1'b1});
    assign rec_a    = alsn_pkg::mul_small_sat(mul_res, {n_reg, 1'b0} - 5'd1);
    assign rec_b    = alsn_pkg::mul_small_sat(prev2_reg, {1'b0, n_reg} + {1'b0, m_reg} - 5'd1);
    assign rec_d    = alsn_pkg::sat_sub(rec_a, rec_b);

    assign norm_idx = alsn_pkg::NORM_IW'(8'(n_reg) * 8'(alsn_pkg::NDIM) + 8'(m_reg));
    assign is_last  = (n_reg == top_reg) && (zonal_reg || (m_reg == n_reg));

    always_comb begin
        if (mul_res > 64'sh0000_0000_7FFF_FFFF) begin
            value_clamped = 32'sh7FFF_FFFF;
        end else if (mul_res < -64'sh0000_0000_8000_0000) begin
            value_clamped = 32'sh8000_0000;
        end else begin
            value_clamped = mul_res[31:0];
        end
    end

    alsn_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .res     (mul_res)
    );

    alsn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    alsn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb begin
        state_next = state_reg;
        xs_next    = xs_reg;
        top_next   = top_reg;
        sign_next  = sign_reg;
        zonal_next = zonal_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        s_next     = s_reg;
        diag_next  = diag_reg;
        prev1_next = prev1_reg;
        prev2_next = prev2_reg;
        mul_req    = '0;
        div_req    = '0;
        sq_start   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cell_addr(n_reg, m_reg);
        mem_wdata  = diag_reg;
        mem_raddr  = cell_addr(n_reg, m_reg);
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    xs_next    = s_arg_x;
                    top_next   = top_eff;
                    sign_next  = sign_flip_reg;
                    zonal_next = zonal_only_reg;
                    n_next     = '0;
                    m_next     = '0;
                    diag_next  = alsn_pkg::ONE_Q32;
                    mem_we     = 1'b1;
                    mem_waddr  = cell_addr(4'd0, 4'd0);
                    mem_wdata  = alsn_pkg::ONE_Q32;
                    if (top_eff == 4'd0) begin
                        state_next = ST_EMIT_RD;
                    end else begin
                        sq_start   = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    s_next        = sq_root;
                    mul_req.start = 1'b1;
                    mul_req.shift = alsn_pkg::SHIFT_Q32;
                    mul_req.a     = xq;
                    mul_req.b     = diag_reg;
                    state_next    = ST_LOW;
                end
            end
            ST_DIAG: begin
                if (mul_done) begin
                    diag_next = diag_val;
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(m_reg, m_reg);
                    mem_wdata = diag_val;
                    if (m_reg < top_reg) begin
                        mul_req.start = 1'b1;
                        mul_req.shift = alsn_pkg::SHIFT_Q32;
                        mul_req.a     = xq;
                        mul_req.b     = diag_val;
                        state_next    = ST_LOW;
                    end else begin
                        n_next     = '0;
                        m_next     = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_LOW: begin
                if (mul_done) begin
                    mem_we     = 1'b1;
                    mem_waddr  = cell_addr(m_reg + 4'd1, m_reg);
                    mem_wdata  = low_val;
                    prev2_next = diag_reg;
                    prev1_next = low_val;
                    n_next     = m_reg + 4'd2;
                    mul_req.start = 1'b1;
                    mul_req.shift = alsn_pkg::SHIFT_Q32;
                    if (({1'b0, m_reg} + 5'd2) <= {1'b0, top_reg}) begin
                        mul_req.a  = xq;
                        mul_req.b  = low_val;
                        state_next = ST_REC;
                    end else begin
                        // column done: advance to the next diagonal term
                        m_next     = m_reg + 4'd1;
                        mul_req.a  = s_wide;
                        mul_req.b  = diag_reg;
                        state_next = ST_DIAG;
                    end
                end
            end
            ST_REC: begin
                if (mul_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = rec_d;
                    div_req.divisor  = n_reg - m_reg;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mem_we     = 1'b1;
                    mem_wdata  = div_quo;
                    prev2_next = prev1_reg;
                    prev1_next = div_quo;
                    mul_req.start = 1'b1;
                    mul_req.shift = alsn_pkg::SHIFT_Q32;
                    if (n_reg < top_reg) begin
                        n_next     = n_reg + 4'd1;
                        mul_req.a  = xq;
                        mul_req.b  = div_quo;
                        state_next = ST_REC;
                    end else begin
                        m_next     = m_reg + 4'd1;
                        mul_req.a  = s_wide;
                        mul_req.b  = diag_reg;
                        state_next = ST_DIAG;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_GO;
            end
            ST_EMIT_GO: begin
                mul_req.start = 1'b1;
                mul_req.shift = alsn_pkg::SHIFT_Q66;
                mul_req.a     = rd_reg;
                mul_req.b     = alsn_pkg::NORM_TAB[norm_idx];
                state_next    = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (mul_done) begin
                    state_next = ST_EMIT_PUSH;
                end
            end
            ST_EMIT_PUSH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else if (zonal_reg || (m_reg == n_reg)) begin
                        n_next     = n_reg + 4'd1;
                        m_next     = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        m_next     = m_reg + 4'd1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            top_order_reg  <= 4'd9;
            sign_flip_reg  <= 1'b1;
            zonal_only_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    alsn_pkg::REG_TOP_ORDER:  top_order_reg  <= cfg_data;
                    alsn_pkg::REG_SIGN_FLIP:  sign_flip_reg  <= cfg_data[0];
                    alsn_pkg::REG_ZONAL_ONLY: zonal_only_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        xs_reg    <= xs_next;
        top_reg   <= top_next;
        sign_reg  <= sign_next;
        zonal_reg <= zonal_next;
        n_reg     <= n_next;
        m_reg     <= m_next;
        s_reg     <= s_next;
        diag_reg  <= diag_next;
        prev1_reg <= prev1_next;
        prev2_reg <= prev2_next;
        if (out_load) begin
            m_degree_n_reg <= n_reg;
            m_mode_m_reg   <= m_reg;
            m_value_reg    <= value_clamped;
            m_last_reg     <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pmem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= pmem[mem_raddr];
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_degree_n = m_degree_n_reg;
    assign m_mode_m   = m_mode_m_reg;
    assign m_value    = m_value_reg;
    assign m_last     = m_last_reg;

endmodule

/* rtl/alsn_check.sv */
// Port-level checker for the normalized Legendre block, with its bind.
module alsn_check #(
    parameter int MAX_DEGREE = 9
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [15:0] s_arg_x,
    input logic               m_valid,
    input logic               m_ready,
    input logic [3:0]         m_degree_n,
    input logic [3:0]         m_mode_m,
    input logic signed [31:0] m_value,
    input logic               m_last,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [1:0]         cfg_index,
    input logic [3:0]         cfg_data
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_degree_n)
            && $stable(m_mode_m) && $stable(m_last))
        else $error("result word changed while stalled");

    a_mode_le_degree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_mode_m <= m_degree_n)
        else $error("mode above degree");

    a_degree_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_degree_n <= 4'(MAX_DEGREE))
        else $error("degree above maximum");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before results were produced");

endmodule

bind assoc_legendre_sph_norm alsn_check u_alsn_check (.*);
